[rtl/hrdr_pkg.sv]
package hrdr_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        sample_time;
    logic signed [31:0] sample_value;
    logic [31:0]        window_start;
    logic [31:0]        window_end;
  } req_t;

  typedef struct packed {
    logic [31:0]        point_time;
    logic signed [31:0] point_value;
    logic               found;
    logic               last;
  } rsp_t;

endpackage

[rtl/history_ring_decimated_readout.sv]
// Ring of DEPTH (power of two, 2..64) timestamped samples with a windowed,
// decimated readout. An add or a clear gives no response. A query walks back
// from the newest entry: a single-port store read, then a threshold compare
// and subtract, for each entry, up to the first entry older than window_start,
// then a final response. The walk waits to pass out a held hit, and the final
// response waits, while the response side stalls. req_ready stays low for the
// whole query. A hit is held back one step so that the final response can
// carry last; a query with no hit returns a single response with found low,
// last high and zero data. selection_step resets to 1; the user must write it
// (cfg_we/cfg_wdata) only while the block is idle, which it does not enforce.
module history_ring_decimated_readout #(
  parameter int DEPTH = hrdr_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  hrdr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output hrdr_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);
  import hrdr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = IDX_W + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0]       state;
  logic [PTR_W-1:0] oldest_ptr;
  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] walk_ptr;
  logic [PTR_W-1:0] remaining;
  logic [PTR_W-1:0] count;
  logic [PTR_W-1:0] walk_ptr_next;
  logic [31:0]      selection_step;
  logic [31:0]      window_start;
  logic [31:0]      thresh;
  logic             thresh_neg;
  logic [32:0]      thresh_diff;
  logic [63:0]      mem [DEPTH];
  logic [63:0]      rd_data;
  logic [31:0]      rd_time;
  logic [31:0]      pend_time;
  logic [31:0]      pend_value;
  logic             has_pend;
  logic             rsp_free;
  logic             rsp_load;
  logic             accept;
  logic             hit;

  assign req_ready     = (state == S_IDLE);
  assign accept        = req_valid && req_ready;
  assign rsp_free      = !rsp_valid || rsp_ready;
  assign count         = write_ptr - oldest_ptr;
  assign walk_ptr_next = walk_ptr - PTR_W'(1);
  assign rd_time       = rd_data[63:32];
  assign hit           = !thresh_neg && (rd_time <= thresh);
  assign thresh_diff   = {1'b0, thresh} - {1'b0, selection_step};
  // a new transaction is loaded into the output register this cycle
  assign rsp_load      = rsp_free &&
                         (((state == S_CHECK) && (rd_time >= window_start) && hit &&
                           has_pend) || (state == S_FINAL));

  always_ff @(posedge clk) begin
    if (accept && req.operation == OP_ADD) begin
      mem[write_ptr[IDX_W-1:0]] <= {req.sample_time, req.sample_value};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= mem[walk_ptr_next[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selection_step <= 32'd1;
    end else if (cfg_we) begin
      selection_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      oldest_ptr <= '0;
      write_ptr  <= '0;
      has_pend   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.operation)
              OP_ADD: begin
                if (count == PTR_W'(DEPTH)) begin
                  oldest_ptr <= oldest_ptr + PTR_W'(1);
                end
                write_ptr <= write_ptr + PTR_W'(1);
              end
              OP_CLEAR: begin
                oldest_ptr <= '0;
                write_ptr  <= '0;
              end
              OP_QUERY: begin
                walk_ptr     <= write_ptr;
                remaining    <= count;
                window_start <= req.window_start;
                thresh       <= req.window_end;
                thresh_neg   <= 1'b0;
                has_pend     <= 1'b0;
                state        <= (count == '0) ? S_FINAL : S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          walk_ptr  <= walk_ptr_next;
          remaining <= remaining - PTR_W'(1);
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_time < window_start) begin
            state <= S_FINAL;
          end else if (hit) begin
            // previous hit goes out now that it is known not to be the last
            if (!has_pend || rsp_free) begin
              if (has_pend) begin
                rsp.point_time  <= pend_time;
                rsp.point_value <= pend_value;
                rsp.found       <= 1'b1;
                rsp.last        <= 1'b0;
              end
              pend_time  <= rd_time;
              pend_value <= rd_data[31:0];
              has_pend   <= 1'b1;
              if (thresh_diff[32]) begin
                thresh_neg <= 1'b1;
              end else begin
                thresh <= thresh_diff[31:0];
              end
              state <= (remaining == '0) ? S_FINAL : S_READ;
            end
          end else begin
            state <= (remaining == '0) ? S_FINAL : S_READ;
          end
        end
        S_FINAL: begin
          if (rsp_free) begin
            rsp.point_time  <= has_pend ? pend_time : 32'd0;
            rsp.point_value <= has_pend ? pend_value : 32'sd0;
            rsp.found       <= has_pend;
            rsp.last        <= 1'b1;
            has_pend        <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/hrdr_checker.sv]
module hrdr_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input hrdr_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  a_miss_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.last)
    else $error("no-hit marker without last");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.point_time == 32'd0 && rsp.point_value == 32'sd0)
    else $error("no-hit marker carries data");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> req_ready && !rsp_valid)
    else $error("block not idle after reset");

endmodule

bind history_ring_decimated_readout hrdr_checker u_hrdr_checker (.*);

[bench/tb_history_ring_decimated_readout.sv]
`timescale 1ns / 1ps

module tb_history_ring_decimated_readout;
  import hrdr_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // predictor state
  logic [31:0] ring_time [DEPTH];
  logic [31:0] ring_value [DEPTH];
  logic [6:0] tail_pos = '0;
  logic [6:0] wr_pos = '0;
  logic [31:0] step_reg = 32'd1;
  rsp_t pending_points[$];

  bit calm = 1'b0;
  int errors = 0;
  int sent = 0;
  int queries = 0;
  int checked = 0;
  int cycles = 0;
  logic [31:0] now_tick = '0;

  history_ring_decimated_readout dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               pending_points.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= 27);
  end

  // compare every accepted response with the oldest pending point
  always @(posedge clk) begin
    rsp_t exp_pt;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_points.size() == 0) begin
        $error("response with nothing pending: time %h value %h found %b last %b",
               rsp.point_time, rsp.point_value, rsp.found, rsp.last);
        errors++;
      end else begin
        exp_pt = pending_points.pop_front();
        checked++;
        if (rsp.point_time !== exp_pt.point_time) begin
          $error("point_time: expected %h, actual %h", exp_pt.point_time, rsp.point_time);
          errors++;
        end
        if (rsp.point_value !== exp_pt.point_value) begin
          $error("point_value: expected %h, actual %h", exp_pt.point_value,
                 rsp.point_value);
          errors++;
        end
        if (rsp.found !== exp_pt.found) begin
          $error("found: expected %b, actual %b", exp_pt.found, rsp.found);
          errors++;
        end
        if (rsp.last !== exp_pt.last) begin
          $error("last: expected %b, actual %b", exp_pt.last, rsp.last);
          errors++;
        end
      end
    end
  end

  function automatic void predict_readout(input req_t r);
    logic [6:0] pos;
    logic [6:0] fill;
    logic [31:0] st;
    longint thresh;
    rsp_t run[$];
    rsp_t pt;
    fill = wr_pos - tail_pos;
    case (r.operation)
      OP_ADD: begin
        ring_time[wr_pos % DEPTH] = r.sample_time;
        ring_value[wr_pos % DEPTH] = r.sample_value;
        if (fill == DEPTH) tail_pos = tail_pos + 7'd1;
        wr_pos = wr_pos + 7'd1;
      end
      OP_CLEAR: begin
        tail_pos = '0;
        wr_pos = '0;
      end
      OP_QUERY: begin
        queries++;
        pos = wr_pos;
        thresh = longint'(r.window_end);
        for (int k = 0; k < fill; k++) begin
          pos = pos - 7'd1;
          st = ring_time[pos % DEPTH];
          if (st < r.window_start) break;
          if (longint'(st) <= thresh) begin
            pt.point_time = st;
            pt.point_value = ring_value[pos % DEPTH];
            pt.found = 1'b1;
            pt.last = 1'b0;
            run = {run, pt};
            thresh = thresh - longint'(step_reg);
          end
        end
        if (run.size() == 0) begin
          pt = '0;
          pt.last = 1'b1;
          run = {run, pt};
        end else begin
          run[run.size() - 1].last = 1'b1;
        end
        pending_points = {pending_points, run};
      end
      default: ;
    endcase
  endfunction

  function automatic req_t mk_req(input logic [1:0] op, input logic [31:0] t,
                                  input logic [31:0] v, input logic [31:0] ws,
                                  input logic [31:0] we);
    req_t r;
    r.operation = op;
    r.sample_time = t;
    r.sample_value = v;
    r.window_start = ws;
    r.window_end = we;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_readout(r);
    sent++;
  endtask

  // wait out all pending points, then let the block settle
  task automatic drain;
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_step(input logic [31:0] s);
    drain();
    cfg_wdata <= s;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    step_reg = s;
  endtask

  task automatic add_sample(input logic [31:0] t, input logic [31:0] v);
    send_req(mk_req(OP_ADD, t, v, $urandom, $urandom));
  endtask

  task automatic query(input logic [31:0] ws, input logic [31:0] we);
    send_req(mk_req(OP_QUERY, $urandom, $urandom, ws, we));
  endtask

  task automatic test_directed;
    query(32'd0, 32'hFFFF_FFFF);                // empty ring
    add_sample(32'd0, 32'h8000_0000);
    add_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_sample(32'd100, 32'hFFFF_FFFF);
    add_sample(32'd200, 32'd0);
    query(32'd0, 32'hFFFF_FFFF);
    query(32'd150, 32'hFFFF_FFFF);              // stops at older sample
    query(32'd300, 32'hFFFF_FFFF);              // newest already too old
    query(32'd0, 32'd50);
    query(32'd0, 32'd0);
    send_req(mk_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(mk_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
    query(32'd0, 32'hFFFF_FFFF);
    add_sample(32'd5, $urandom);
    query(32'd5, 32'd5);
  endtask

  task automatic test_step_extremes;
    set_step(32'hFFFF_FFFF);
    add_sample(32'd7, $urandom);
    add_sample(32'd8, $urandom);
    add_sample(32'd9, $urandom);
    query(32'd0, 32'd10);                       // threshold goes negative
    set_step(32'd0);
    query(32'd0, 32'd10);                       // threshold never moves
    query(32'd6, 32'd8);
    set_step(32'd1);
    query(32'd0, 32'd9);
  endtask

  task automatic test_ring_wrap;
    set_step(32'd1);
    calm = 1'b1;
    send_req(mk_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
    now_tick = 32'd1000;
    for (int i = 0; i < DEPTH + 6; i++) begin
      now_tick = now_tick + 32'd1;
      add_sample(now_tick, $urandom);
    end
    query(32'd0, 32'hFFFF_FFFF);                // full ring, every entry hits
    drain();
    calm = 1'b0;
    set_step(32'd3);
    query(32'd0, now_tick);
    query(now_tick - 32'd20, now_tick - 32'd2);
  endtask

  task automatic random_burst(input int count);
    int pick;
    logic [31:0] t;
    logic [31:0] ws;
    logic [31:0] we;
    int span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        if ($urandom_range(9) == 0) begin
          t = $urandom;
        end else begin
          now_tick = now_tick + $urandom_range(1, 6);
          t = now_tick;
        end
        add_sample(t, $urandom);
      end else if (pick < 90) begin
        span = $urandom_range(0, 400);
        ws = (now_tick > span) ? now_tick - span : 32'd0;
        we = now_tick - $urandom_range(0, 40);
        if ($urandom_range(9) == 0) ws = $urandom;
        if ($urandom_range(9) == 0) we = $urandom;
        else if ($urandom_range(14) == 0) we = 32'hFFFF_FFFF;
        query(ws, we);
      end else if (pick < 94) begin
        send_req(mk_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
      end else if (pick < 97) begin
        send_req(mk_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
      end else begin
        drain();                                // hold off until quiet
      end
    end
  endtask

  task automatic test_random;
    now_tick = $urandom_range(0, 1000);
    set_step($urandom_range(1, 8));
    random_burst(60);
    set_step(32'd1);
    random_burst(60);
    // large step, timestamps crossing the top of the tick range
    set_step($urandom);
    now_tick = 32'hFFFF_FF00;
    random_burst(60);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_step_extremes();
    test_ring_wrap();
    test_random();
    drain();
    $display("%0d requests sent, %0d queries, %0d responses checked", sent, queries,
             checked);
    $display("steps from 0 to max, ring overflow and wrap, empty and no-hit queries");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[history_ring_decimated_readout.f]
rtl/hrdr_pkg.sv
rtl/history_ring_decimated_readout.sv
rtl/hrdr_checker.sv
bench/tb_history_ring_decimated_readout.sv
